@@ rtl/bp2_pkg.sv @@
// Shared constants, types and register codes for the two-level branch predictor.
package bp2_pkg;

   localparam int HIST_BITS     = 12;
   localparam int ADDR_SEL_BITS = 8;
   localparam int HIST_SET_BITS = 4;
   localparam int PAT_SET_BITS  = 4;

   localparam int HT_LOG   = (ADDR_SEL_BITS > HIST_SET_BITS) ? ADDR_SEL_BITS : HIST_SET_BITS;
   localparam int PSEL_LOG = (ADDR_SEL_BITS > PAT_SET_BITS) ? ADDR_SEL_BITS : PAT_SET_BITS;
   localparam int HT_DEPTH = 1 << HT_LOG;
   localparam int PT_AW    = PSEL_LOG + HIST_BITS;
   localparam int PT_DEPTH = 1 << PT_AW;

   localparam int CTR_BITS = 2;
   localparam logic [CTR_BITS-1:0] CTR_MAX   = CTR_BITS'(3);
   localparam logic [CTR_BITS-1:0] CTR_MIN   = '0;
   localparam logic [CTR_BITS-1:0] CTR_TAKEN = CTR_BITS'(2);

   localparam int PC_BITS  = 64;
   localparam int CSR_AW   = 4;
   localparam int CSR_DW   = 32;

   localparam logic [1:0] CSR_HIST_MODE = 2'd0;
   localparam logic [1:0] CSR_PAT_MODE  = 2'd1;
   localparam logic [1:0] CSR_SET_LSB   = 2'd2;

   localparam logic [1:0] HMODE_GLOBAL = 2'd0;
   localparam logic [1:0] HMODE_ADDR   = 2'd1;
   localparam logic [1:0] PMODE_GLOBAL = 2'd0;
   localparam logic [1:0] PMODE_SET    = 2'd1;

   localparam logic [1:0] HMODE_RESET   = 2'd2;
   localparam logic [1:0] PMODE_RESET   = 2'd2;
   localparam logic [5:0] SET_LSB_RESET = 6'd28;

   localparam logic ACT_PREDICT = 1'b0;
   localparam logic ACT_UPDATE  = 1'b1;

   typedef struct packed {
      logic [1:0] hist_mode;
      logic [1:0] pat_mode;
      logic [5:0] set_lsb;
   } bp2_cfg_type;

   typedef struct packed {
      logic load;
      logic clr;
      logic pat_rd;
      logic commit;
      logic respond;
   } bp2_cmd_type;

   typedef struct packed {
      logic clr_last;
      logic is_update;
      logic rsp_free;
   } bp2_status_type;

endpackage

@@ rtl/bp2_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module bp2_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/bp2_csr.sv @@
// Configuration registers behind the APB-style port.
module bp2_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [bp2_pkg::CSR_AW-1:0]   paddr,
   input  logic [bp2_pkg::CSR_DW-1:0]   pwdata,
   output logic [bp2_pkg::CSR_DW-1:0]   prdata,
   output bp2_pkg::bp2_cfg_type         cfg
);

   bp2_pkg::bp2_cfg_type cfg_ff;
   bp2_pkg::bp2_cfg_type cfg_in;
   logic                 wr_beat;
   logic [1:0]           reg_idx;

   assign wr_beat = psel & penable & pwrite;
   assign reg_idx = paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_beat) begin
         unique case (reg_idx)
            bp2_pkg::CSR_HIST_MODE: cfg_in.hist_mode = pwdata[1:0];
            bp2_pkg::CSR_PAT_MODE:  cfg_in.pat_mode  = pwdata[1:0];
            bp2_pkg::CSR_SET_LSB:   cfg_in.set_lsb   = pwdata[5:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hist_mode <= bp2_pkg::HMODE_RESET;
         cfg_ff.pat_mode  <= bp2_pkg::PMODE_RESET;
         cfg_ff.set_lsb   <= bp2_pkg::SET_LSB_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         bp2_pkg::CSR_HIST_MODE: prdata = bp2_pkg::CSR_DW'(cfg_ff.hist_mode);
         bp2_pkg::CSR_PAT_MODE:  prdata = bp2_pkg::CSR_DW'(cfg_ff.pat_mode);
         bp2_pkg::CSR_SET_LSB:   prdata = bp2_pkg::CSR_DW'(cfg_ff.set_lsb);
         default:                prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/bp2_ctrl.sv @@
// Sequencer: table clear after reset, then history read, counter read, and commit (update) or respond (predict).
module bp2_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  bp2_pkg::bp2_status_type status,
   output bp2_pkg::bp2_cmd_type    cmd
);

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_PAT   = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      req_ready   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clr = 1'b1;
            if (status.clr_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_PAT;
            end
         end
         S_PAT: begin
            cmd.pat_rd = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (status.is_update) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end else if (status.rsp_free) begin
               cmd.respond = 1'b1;
               state_in    = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ rtl/bp2_dp.sv @@
// Datapath: item registers, history and counter tables, result register.
module bp2_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  bp2_pkg::bp2_cfg_type          cfg,
   input  bp2_pkg::bp2_cmd_type          cmd,
   output bp2_pkg::bp2_status_type       status,
   input  logic                          req_action,
   input  logic [bp2_pkg::PC_BITS-1:0]   req_pc,
   input  logic                          req_is_direct,
   input  logic [bp2_pkg::PC_BITS-1:0]   req_target,
   input  logic                          req_was_taken,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pred_taken,
   output logic [bp2_pkg::PC_BITS-1:0]   rsp_pred_target
);

   localparam int HB  = bp2_pkg::HIST_BITS;
   localparam int HTL = bp2_pkg::HT_LOG;
   localparam int PSL = bp2_pkg::PSEL_LOG;
   localparam int PAW = bp2_pkg::PT_AW;
   localparam int CB  = bp2_pkg::CTR_BITS;
   localparam int PCB = bp2_pkg::PC_BITS;

   // item registers
   logic           action_ff;
   logic           direct_ff;
   logic           taken_ff;
   logic [PCB-1:0] target_ff;
   logic [HTL-1:0] hidx_ff;
   logic [PSL-1:0] psel_ff;
   logic [HB-1:0]  hist_ff;
   logic [PAW-1:0] pidx_ff;
   logic           hvalid_rd_ff;

   logic [bp2_pkg::HT_DEPTH-1:0] hvalid_ff;
   logic [PAW-1:0] clr_cnt_ff;
   logic [PCB-1:0] last_ind_ff;
   logic           rsp_valid_ff;
   logic           pred_taken_ff;
   logic [PCB-1:0] pred_target_ff;

   logic [PCB-1:0] set_shift;
   logic [HTL-1:0] hidx_in;
   logic [PSL-1:0] psel_in;
   logic [HB-1:0]  hram_rdata;
   logic [HB-1:0]  hist_val;
   logic [PAW-1:0] pidx_in;
   logic [CB-1:0]  ctr;
   logic [CB-1:0]  ctr_new;
   logic           upd_commit;
   logic           pt_we;
   logic [PAW-1:0] pt_waddr;
   logic [CB-1:0]  pt_wdata;
   logic [HB-1:0]  hist_new;

   assign set_shift = req_pc >> cfg.set_lsb;

   always_comb begin
      priority if (cfg.hist_mode == bp2_pkg::HMODE_GLOBAL) begin
         hidx_in = '0;
      end else if (cfg.hist_mode == bp2_pkg::HMODE_ADDR) begin
         hidx_in = HTL'(req_pc[bp2_pkg::ADDR_SEL_BITS-1:0]);
      end else begin
         hidx_in = HTL'(set_shift[bp2_pkg::HIST_SET_BITS-1:0]);
      end
      priority if (cfg.pat_mode == bp2_pkg::PMODE_GLOBAL) begin
         psel_in = '0;
      end else if (cfg.pat_mode == bp2_pkg::PMODE_SET) begin
         psel_in = PSL'(set_shift[bp2_pkg::PAT_SET_BITS-1:0]);
      end else begin
         psel_in = PSL'(req_pc[bp2_pkg::ADDR_SEL_BITS-1:0]);
      end
   end

   // never-written history entries read as zero
   assign hist_val = hvalid_rd_ff ? hram_rdata : '0;
   assign pidx_in  = {psel_ff, hist_val};

   always_comb begin
      if (taken_ff) begin
         ctr_new = (ctr == bp2_pkg::CTR_MAX) ? ctr : CB'(ctr + 1'b1);
      end else begin
         ctr_new = (ctr == bp2_pkg::CTR_MIN) ? ctr : CB'(ctr - 1'b1);
      end
   end

   assign hist_new   = HB'({hist_ff, taken_ff});
   assign upd_commit = cmd.commit;
   assign pt_we      = cmd.clr | upd_commit;
   assign pt_waddr   = cmd.clr ? clr_cnt_ff : pidx_ff;
   assign pt_wdata   = cmd.clr ? '0 : ctr_new;

   bp2_ram #(
      .WIDTH (HB),
      .DEPTH (bp2_pkg::HT_DEPTH)
   ) u_hist_ram (
      .clock   (clock),
      .wr_en   (upd_commit),
      .wr_addr (hidx_ff),
      .wr_data (hist_new),
      .rd_en   (cmd.load),
      .rd_addr (hidx_in),
      .rd_data (hram_rdata)
   );

   bp2_ram #(
      .WIDTH (CB),
      .DEPTH (bp2_pkg::PT_DEPTH)
   ) u_pat_ram (
      .clock   (clock),
      .wr_en   (pt_we),
      .wr_addr (pt_waddr),
      .wr_data (pt_wdata),
      .rd_en   (cmd.pat_rd),
      .rd_addr (pidx_in),
      .rd_data (ctr)
   );

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff    <= req_action;
         direct_ff    <= req_is_direct;
         taken_ff     <= req_was_taken;
         target_ff    <= req_target;
         hidx_ff      <= hidx_in;
         psel_ff      <= psel_in;
         hvalid_rd_ff <= hvalid_ff[hidx_in];
      end
      if (cmd.pat_rd) begin
         hist_ff <= hist_val;
         pidx_ff <= pidx_in;
      end
      if (cmd.respond) begin
         pred_taken_ff  <= (ctr >= bp2_pkg::CTR_TAKEN);
         pred_target_ff <= direct_ff ? target_ff : last_ind_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hvalid_ff    <= '0;
         clr_cnt_ff   <= '0;
         last_ind_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (upd_commit) begin
            hvalid_ff[hidx_ff] <= 1'b1;
            if (!direct_ff) begin
               last_ind_ff <= target_ff;
            end
         end
         if (cmd.respond) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.clr_last  = &clr_cnt_ff;
   assign status.is_update = (action_ff == bp2_pkg::ACT_UPDATE);
   assign status.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pred_taken  = pred_taken_ff;
   assign rsp_pred_target = pred_target_ff;

endmodule

@@ rtl/two_level_branch_predictor_top.sv @@
// Two-level adaptive branch predictor (GAg through SAp), top level.
// Each beat runs in order: accept with the history table read, the counter
// table read indexed by that history, then the commit (update) or the result
// load (predict); the second table read depends on the first. A predict
// beat waits in its last cycle while the result register is still full, and
// a new beat is taken while a finished result waits to be taken. After reset
// a clearing pass zeroes all 1,048,576 entries of the counter table, one entry
// per cycle, and no beat is accepted until it ends; configuration writes are
// taken throughout. An update beat gives no result.
module two_level_branch_predictor_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_action,
   input  logic [bp2_pkg::PC_BITS-1:0]   req_pc,
   input  logic                          req_is_direct,
   input  logic [bp2_pkg::PC_BITS-1:0]   req_target,
   input  logic                          req_was_taken,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_pred_taken,
   output logic [bp2_pkg::PC_BITS-1:0]   rsp_pred_target,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [bp2_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [bp2_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [bp2_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);

   bp2_pkg::bp2_cfg_type    cfg;
   bp2_pkg::bp2_cmd_type    cmd;
   bp2_pkg::bp2_status_type status;

   assign csr_pready = 1'b1;

   bp2_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   bp2_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   bp2_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .cmd             (cmd),
      .status          (status),
      .req_action      (req_action),
      .req_pc          (req_pc),
      .req_is_direct   (req_is_direct),
      .req_target      (req_target),
      .req_was_taken   (req_was_taken),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pred_taken  (rsp_pred_taken),
      .rsp_pred_target (rsp_pred_target)
   );

   // an accepted beat reads the counter table in the next cycle
   a_accept_then_pat_rd: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> cmd.pat_rd)
      else $error("counter read did not follow accepted beat");

   // a result only appears out of a busy cycle, never from idle
   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready && cmd.respond))
      else $error("result appeared without a respond command");

   // a committed update frees the block for the next beat
   a_commit_then_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> req_ready)
      else $error("block not ready after update commit");

endmodule
